FILE: rtl/gha_pkg.sv
// Shared constants, request codes and inter-module types for the handle allocator.
package gha_pkg;

  // Build defaults
  localparam int SLOTS_DEF    = 256;
  localparam int GEN_BITS_DEF = 32;

  // Search grouping: slots are scanned in groups of this many bits
  localparam int GROUP     = 16;
  localparam int GROUP_W   = 4;
  localparam int MAX_IDX_W = 16;

  // Request kinds
  localparam logic [2:0] KIND_ALLOC    = 3'd0;
  localparam logic [2:0] KIND_FREE     = 3'd1;
  localparam logic [2:0] KIND_VALIDATE = 3'd2;
  localparam logic [2:0] KIND_READ     = 3'd3;
  localparam logic [2:0] KIND_FIND     = 3'd4;

  // Configuration register indexes
  localparam int          CFG_IDX_W        = 1;
  localparam logic [0:0]  REG_HANDLE_COUNT = 1'd0;
  localparam logic [0:0]  REG_BLOCK_SIZE   = 1'd1;

  // Register reset values
  localparam logic [8:0]  HANDLE_COUNT_RST = 9'd256;
  localparam logic [16:0] BLOCK_SIZE_RST   = 17'd64;

  // Body offset width
  localparam int OFFSET_W = 24;

  // Search result handed back to the sequencer
  typedef struct packed {
    logic                 done;
    logic                 found;
    logic [MAX_IDX_W-1:0] slot;
  } srch_res_t;

  // Busy-bit update that follows a generation write
  typedef struct packed {
    logic                 we;
    logic [MAX_IDX_W-1:0] addr;
    logic                 parity;
  } busy_upd_t;

endpackage

FILE: rtl/gha_gen_mem.sv
// Generation table: synchronous single-port-read memory with written flags.
module gha_gen_mem import gha_pkg::*; #(
  parameter int SLOTS    = SLOTS_DEF,
  parameter int GEN_BITS = GEN_BITS_DEF,
  localparam int IDX_W   = $clog2(SLOTS)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                rd_en,
  input  logic [IDX_W-1:0]    rd_addr,
  output logic [GEN_BITS-1:0] rd_data,
  input  logic                wr_en,
  input  logic [IDX_W-1:0]    wr_addr,
  input  logic [GEN_BITS-1:0] wr_data
);

  logic [GEN_BITS-1:0] mem [SLOTS];
  logic [GEN_BITS-1:0] mem_q;
  logic [SLOTS-1:0]    written;
  logic                written_q;

  // Storage array, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  // Entries never written read as zero (reset generation)
  always_ff @(posedge clk) begin
    if (rst) begin
      written   <= '0;
      written_q <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        written_q <= written[rd_addr];
      end
    end
  end

  assign rd_data = written_q ? mem_q : '0;

endmodule

FILE: rtl/gha_search.sv
// Busy-bit vector and two-level priority search for allocate and find.
module gha_search import gha_pkg::*; #(
  parameter int SLOTS   = SLOTS_DEF,
  localparam int IDX_W  = $clog2(SLOTS),
  localparam int CNT_W  = $clog2(SLOTS + 1),
  localparam int NGRP   = (SLOTS + GROUP - 1) / GROUP,
  localparam int GRP_W  = (NGRP > 1) ? $clog2(NGRP) : 1,
  localparam int PAD    = NGRP * GROUP
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  logic             want_busy,
  input  logic             start_ok,
  input  logic [IDX_W-1:0] start_idx,
  input  logic [CNT_W-1:0] count,
  input  busy_upd_t        upd,
  output srch_res_t        res
);

  logic [SLOTS-1:0]   busy_vec;
  logic [PAD-1:0]     cand_d;
  logic [PAD-1:0]     cand_q;
  logic [NGRP-1:0]    grp_hit;
  logic [GRP_W-1:0]   grp_d;
  logic [GRP_W-1:0]   grp_q;
  logic               grp_any_q;
  logic               v1;
  logic               v2;
  logic [GROUP-1:0]   grp_bits;
  logic [GROUP_W-1:0] bit_d;
  logic [GRP_W+GROUP_W-1:0] slot_full;

  // Busy bits mirror the parity of each generation
  always_ff @(posedge clk) begin
    if (rst) begin
      busy_vec <= '0;
    end else if (upd.we) begin
      busy_vec[upd.addr[IDX_W-1:0]] <= upd.parity;
    end
  end

  // Candidate slots: wanted state, below count, at or after start
  always_comb begin
    cand_d = '0;
    for (int i = 0; i < SLOTS; i++) begin
      cand_d[i] = (busy_vec[i] == want_busy) && start_ok &&
                  (CNT_W'(i) < count) && (IDX_W'(i) >= start_idx);
    end
  end

  // Group level: lowest group holding a candidate
  always_comb begin
    grp_d = '0;
    for (int g = 0; g < NGRP; g++) begin
      grp_hit[g] = |cand_q[g*GROUP +: GROUP];
    end
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_hit[g]) begin
        grp_d = GRP_W'(g);
      end
    end
  end

  // Bit level inside the chosen group
  always_comb begin
    bit_d    = '0;
    grp_bits = cand_q[{grp_q, GROUP_W'(0)} +: GROUP];
    for (int b = GROUP - 1; b >= 0; b--) begin
      if (grp_bits[b]) begin
        bit_d = GROUP_W'(b);
      end
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (load) begin
      cand_q <= cand_d;
    end
    if (v1) begin
      grp_q     <= grp_d;
      grp_any_q <= |grp_hit;
    end
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= load;
      v2 <= v1;
    end
  end

  assign slot_full = {grp_q, bit_d};
  assign res.done  = v2;
  assign res.found = grp_any_q;
  assign res.slot  = MAX_IDX_W'(slot_full);

endmodule

FILE: rtl/generational_handle_allocator.sv
// Top level: request sequencer, config registers and result register.
//
//  channel  | signals                                           | handshake
//  ---------+---------------------------------------------------+--------------------------
//  request  | kind, slot_index, handle_generation               | start & !busy
//  result   | ok, result_index, result_generation,              | done, one cycle, no stall
//           | body_offset, body_size                            |
//  config   | cfg_index, cfg_data                               | cfg_write, immediate
//
// Free, validate, read and unknown kinds go through the table read, then
// modify/write-back and the result register. Allocate and find first pass
// the group and bit levels of the busy-bit search.
// Reset (rst, synchronous) frees every slot and loads handle_count 256, block_size 64.
// Results cannot be held off; busy is low again in the cycle done is shown.
module generational_handle_allocator import gha_pkg::*; #(
  parameter int SLOTS    = SLOTS_DEF,
  parameter int GEN_BITS = GEN_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [2:0]           kind,
  input  logic [31:0]          slot_index,
  input  logic [31:0]          handle_generation,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [16:0]          cfg_data,
  output logic                 done,
  output logic                 ok,
  output logic [7:0]           result_index,
  output logic [31:0]          result_generation,
  output logic [OFFSET_W-1:0]  body_offset,
  output logic [16:0]          body_size
);

  localparam int IDX_W  = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int PROD_W = (IDX_W + 17 > OFFSET_W) ? IDX_W + 17 : OFFSET_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [8:0]          handle_count;
  logic [16:0]         block_size;
  logic [CNT_W-1:0]    count_eff;
  logic                in_range;
  logic                accept;
  logic                is_search;

  logic [1:0]          state;
  logic [1:0]          state_next;
  logic [2:0]          kind_q;
  logic [IDX_W-1:0]    idx_q;
  logic [31:0]         gen_q;
  logic                hit_q;

  logic                rd_en;
  logic [IDX_W-1:0]    rd_addr;
  logic [GEN_BITS-1:0] rd_data;
  logic                wr_en;
  logic [GEN_BITS-1:0] gen_inc;
  logic                gen_match;
  logic [PROD_W-1:0]   prod;
  logic [31:0]         idx_ext;

  logic                ok_d;
  logic [7:0]          index_d;
  logic [31:0]         gen_d;
  logic [OFFSET_W-1:0] offset_d;
  logic [16:0]         size_d;

  srch_res_t           srch;
  busy_upd_t           upd;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      handle_count <= HANDLE_COUNT_RST;
      block_size   <= BLOCK_SIZE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_HANDLE_COUNT: handle_count <= cfg_data[8:0];
        REG_BLOCK_SIZE:   block_size   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective slot count, clamped to the built table size
  assign count_eff = (32'(handle_count) > 32'(SLOTS)) ? CNT_W'(SLOTS) : CNT_W'(handle_count);
  assign in_range  = slot_index < 32'(count_eff);

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign is_search = (kind == KIND_ALLOC) || (kind == KIND_FIND);

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (accept) state_next = is_search ? S_SCAN : S_EXEC;
      S_SCAN: if (srch.done) state_next = S_EXEC;
      S_EXEC: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Request registers; search kinds take the found slot as their index
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q <= kind;
      idx_q  <= slot_index[IDX_W-1:0];
      gen_q  <= handle_generation;
      hit_q  <= in_range;
    end else if (state == S_SCAN && srch.done) begin
      idx_q <= srch.slot[IDX_W-1:0];
      hit_q <= srch.found;
    end
  end

  // Table read: direct index at accept, found slot after a search
  assign rd_en   = (accept && !is_search) || (state == S_SCAN && srch.done);
  assign rd_addr = (state == S_IDLE) ? slot_index[IDX_W-1:0] : srch.slot[IDX_W-1:0];

  gha_search #(
    .SLOTS(SLOTS)
  ) u_search (
    .clk      (clk),
    .rst      (rst),
    .load     (accept && is_search),
    .want_busy(kind == KIND_FIND),
    .start_ok ((kind == KIND_FIND) ? in_range : 1'b1),
    .start_idx((kind == KIND_FIND) ? slot_index[IDX_W-1:0] : '0),
    .count    (count_eff),
    .upd      (upd),
    .res      (srch)
  );

  gha_gen_mem #(
    .SLOTS   (SLOTS),
    .GEN_BITS(GEN_BITS)
  ) u_mem (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr_en  (wr_en),
    .wr_addr(idx_q),
    .wr_data(gen_inc)
  );

  // Modify step
  assign gen_inc   = rd_data + GEN_BITS'(1);
  assign gen_match = hit_q && (32'(rd_data) == gen_q);
  assign prod      = PROD_W'(idx_q) * PROD_W'(block_size);
  assign idx_ext   = 32'(idx_q);

  always_comb begin
    wr_en    = 1'b0;
    ok_d     = 1'b0;
    index_d  = '0;
    gen_d    = '0;
    offset_d = '0;
    size_d   = '0;
    if (state == S_EXEC) begin
      case (kind_q)
        KIND_ALLOC: if (hit_q) begin
          wr_en    = 1'b1;
          ok_d     = 1'b1;
          index_d  = idx_ext[7:0];
          gen_d    = 32'(gen_inc);
          offset_d = prod[OFFSET_W-1:0];
          size_d   = block_size;
        end
        KIND_FREE: if (gen_match) begin
          wr_en = 1'b1;
          ok_d  = 1'b1;
        end
        KIND_VALIDATE: if (gen_match) begin
          ok_d     = 1'b1;
          index_d  = idx_ext[7:0];
          gen_d    = 32'(rd_data);
          offset_d = prod[OFFSET_W-1:0];
        end
        KIND_READ, KIND_FIND: if (hit_q) begin
          ok_d    = 1'b1;
          index_d = idx_ext[7:0];
          gen_d   = 32'(rd_data);
        end
        default: ;
      endcase
    end
  end

  assign upd.we     = wr_en;
  assign upd.addr   = MAX_IDX_W'(idx_q);
  assign upd.parity = gen_inc[0];

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == S_EXEC);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EXEC) begin
      ok                <= ok_d;
      result_index      <= index_d;
      result_generation <= gen_d;
      body_offset       <= offset_d;
      body_size         <= size_d;
    end
  end

endmodule

FILE: rtl/gha_checker.sv
// Port-level checker for the handle allocator, bound to the top level.
module gha_checker import gha_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input logic                 done,
  input logic                 ok,
  input logic [7:0]           result_index,
  input logic [31:0]          result_generation,
  input logic [OFFSET_W-1:0]  body_offset,
  input logic [16:0]          body_size
);

  // An accepted item keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  // A result only follows a busy cycle
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without work in progress");

  // Block is free again when its result is shown
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("busy while showing a result");

  // Failed requests carry all-zero fields
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    done && !ok |-> result_index == 8'd0 && result_generation == 32'd0 &&
                    body_offset == '0 && body_size == 17'd0)
    else $error("failed request with nonzero result fields");

endmodule

bind generational_handle_allocator gha_checker u_gha_checker (.*);
